// ===== hdl/aimd_pkg.sv =====
package aimd_pkg;

    localparam int TIME_W   = 48;
    localparam int WIN_W    = 16;
    localparam int CNT_W    = 32;
    localparam int BETA_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 48;

    // input item kinds
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ACK  = 2'd1;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_BADTIME   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_DECREASED = 3'd4;

    // classified operations handed from front to back
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_GROW   = 3'd1;
    localparam logic [2:0] OP_CUT    = 3'd2;
    localparam logic [2:0] OP_BAD    = 3'd3;
    localparam logic [2:0] OP_IGNORE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 4'd3;

    localparam logic [WIN_W-1:0]  WIN_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [BETA_W-1:0] BETA_RESET = 16'd32768;
    localparam logic [TIME_W-1:0] GAP_RESET  = 48'd1;

    typedef struct packed {
        logic [2:0]        op;
        logic [TIME_W-1:0] delay;
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] delay_threshold;
        logic [BETA_W-1:0] beta_q16;
        logic [TIME_W-1:0] packet_gap;
    } cfg_t;

    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] value;
    } budget_wr_t;

endpackage

// ===== hdl/aimd_req_if.sv =====
interface aimd_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [aimd_pkg::TIME_W-1:0] arrive_time;
    logic [aimd_pkg::TIME_W-1:0] sent_stamp;

    modport source (output valid, mode, arrive_time, sent_stamp, input ready);
    modport sink   (input valid, mode, arrive_time, sent_stamp, output ready);
endinterface

// ===== hdl/aimd_rsp_if.sv =====
interface aimd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        send_packet;
    logic [aimd_pkg::TIME_W-1:0] next_gap;
    logic [aimd_pkg::WIN_W-1:0]  window;
    logic [aimd_pkg::WIN_W-1:0]  in_flight;
    logic [aimd_pkg::TIME_W-1:0] rtt_delay;
    logic [2:0]                  status;

    modport source (output valid, send_packet, next_gap, window, in_flight, rtt_delay,
                    status, input ready);
    modport sink   (input valid, send_packet, next_gap, window, in_flight, rtt_delay,
                    status, output ready);
endinterface

// ===== hdl/aimd_cfg_if.sv =====
interface aimd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [aimd_pkg::CFG_IDX_W-1:0] index;
    logic [aimd_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/aimd_front.sv =====
module aimd_front (
    aimd_req_if.sink                    req,
    input  logic [aimd_pkg::TIME_W-1:0] delay_threshold,
    input  logic                        q_full,
    output logic                        push,
    output aimd_pkg::cmd_t              cmd
);

    logic [aimd_pkg::TIME_W:0]   diff;
    logic [aimd_pkg::TIME_W-1:0] delay;
    logic                        bad_time;
    logic                        below;
    logic [2:0]                  op;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    // borrow out of the subtract flags an ack from the future
    assign diff     = {1'b0, req.arrive_time} - {1'b0, req.sent_stamp};
    assign bad_time = diff[aimd_pkg::TIME_W];
    assign delay    = diff[aimd_pkg::TIME_W-1:0];
    assign below    = delay < delay_threshold;

    always_comb
    begin
        case (req.mode)
            aimd_pkg::MODE_TICK: op = aimd_pkg::OP_TICK;
            aimd_pkg::MODE_ACK:
            begin
                if (bad_time)
                    op = aimd_pkg::OP_BAD;
                else if (below)
                    op = aimd_pkg::OP_GROW;
                else
                    op = aimd_pkg::OP_CUT;
            end
            default: op = aimd_pkg::OP_IGNORE;
        endcase
    end

    assign cmd.op    = op;
    assign cmd.delay = (op == aimd_pkg::OP_GROW || op == aimd_pkg::OP_CUT) ? delay : '0;

endmodule

// ===== hdl/aimd_queue.sv =====
module aimd_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aimd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output aimd_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aimd_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

// ===== hdl/aimd_back.sv =====
module aimd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  aimd_pkg::cmd_t       cmd,
    output logic                 pop,
    input  aimd_pkg::cfg_t       cfg_regs,
    input  aimd_pkg::budget_wr_t budget_wr,
    aimd_rsp_if.source           rsp
);

    logic [aimd_pkg::WIN_W-1:0]  cwnd_reg, cwnd_next;
    logic [aimd_pkg::WIN_W-1:0]  outstanding_reg, outstanding_next;
    logic [aimd_pkg::CNT_W-1:0]  acked_reg, acked_next;
    logic [aimd_pkg::CNT_W-1:0]  budget_reg, budget_next;

    logic                        valid_reg, valid_next;
    logic                        send_reg, send_next;
    logic [aimd_pkg::TIME_W-1:0] gap_reg, gap_next;
    logic [aimd_pkg::TIME_W-1:0] delay_reg;
    logic [2:0]                  status_reg, status_next;

    logic [aimd_pkg::WIN_W-1:0]  out_dec;
    logic [aimd_pkg::WIN_W-1:0]  cwnd_inc;
    logic [2*aimd_pkg::WIN_W-1:0] product;
    logic [aimd_pkg::WIN_W-1:0]  cut_win;

    // output register frees up when empty or being taken this cycle
    assign pop = q_valid && (!valid_reg || rsp.ready);

    assign out_dec  = (outstanding_reg != '0) ? outstanding_reg - 1'b1 : outstanding_reg;
    assign cwnd_inc = (cwnd_reg != aimd_pkg::WIN_MAX) ? cwnd_reg + 1'b1 : cwnd_reg;
    assign product  = cwnd_reg * cfg_regs.beta_q16;
    assign cut_win  = product[2*aimd_pkg::WIN_W-1:aimd_pkg::WIN_W];

    always_comb
    begin
        cwnd_next        = cwnd_reg;
        outstanding_next = outstanding_reg;
        acked_next       = acked_reg;
        budget_next      = budget_reg;
        send_next        = 1'b0;
        gap_next         = '0;
        status_next      = aimd_pkg::ST_OK;
        case (cmd.op)
            aimd_pkg::OP_TICK:
            begin
                if (budget_reg == '0)
                    status_next = aimd_pkg::ST_EMPTY;
                else
                begin
                    gap_next = cfg_regs.packet_gap;
                    if (outstanding_reg < cwnd_reg)
                    begin
                        outstanding_next = outstanding_reg + 1'b1;
                        budget_next      = budget_reg - 1'b1;
                        send_next        = 1'b1;
                    end
                end
            end
            aimd_pkg::OP_GROW:
            begin
                cwnd_next  = cwnd_inc;
                acked_next = (acked_reg != aimd_pkg::CNT_MAX) ? acked_reg + 1'b1 : acked_reg;
                // extra send on a good ack, not charged to the budget
                if (out_dec < cwnd_inc)
                begin
                    outstanding_next = out_dec + 1'b1;
                    send_next        = 1'b1;
                end
                else
                    outstanding_next = out_dec;
            end
            aimd_pkg::OP_CUT:
            begin
                cwnd_next        = (cut_win == '0) ? aimd_pkg::WIN_W'(1) : cut_win;
                outstanding_next = '0;
                status_next      = aimd_pkg::ST_DECREASED;
            end
            aimd_pkg::OP_BAD: status_next = aimd_pkg::ST_BADTIME;
            default:          status_next = aimd_pkg::ST_IGNORED;
        endcase
    end

    always_comb
    begin
        if (pop)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwnd_reg        <= aimd_pkg::WIN_W'(1);
            outstanding_reg <= '0;
            acked_reg       <= '0;
            budget_reg      <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                cwnd_reg        <= cwnd_next;
                outstanding_reg <= outstanding_next;
                acked_reg       <= acked_next;
            end
            if (budget_wr.load)
                budget_reg <= budget_wr.value;
            else if (pop)
                budget_reg <= budget_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            send_reg   <= send_next;
            gap_reg    <= gap_next;
            delay_reg  <= cmd.delay;
            status_reg <= status_next;
        end
    end

    // window and in-flight after the item are the updated state itself
    assign rsp.valid       = valid_reg;
    assign rsp.send_packet = send_reg;
    assign rsp.next_gap    = gap_reg;
    assign rsp.window      = cwnd_reg;
    assign rsp.in_flight   = outstanding_reg;
    assign rsp.rtt_delay   = delay_reg;
    assign rsp.status      = status_reg;

    a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cwnd_reg != '0)
        else $error("window reached zero");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= cwnd_reg)
        else $error("in-flight above window");

    a_budget_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(budget_wr.load) |-> budget_reg <= $past(budget_reg))
        else $error("budget grew without a write");

    a_acked_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        acked_reg >= $past(acked_reg))
        else $error("acked count went down");

endmodule

// ===== hdl/aimd_congestion_window.sv =====
// a word accepted into the queue reaches rsp once the back end pops it into its output register
// throughput: one word per cycle while rsp.ready takes each result; the back end updates state on each pop
// a queue (two entries by default, QUEUE_DEPTH) between classify and update lets each side stall on its own
// reset: window 1, in-flight 0, budget 0, threshold 0, beta 32768, gap 1
// writing the budget register also reloads the remaining budget
module aimd_congestion_window #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    aimd_req_if.sink   req,
    aimd_rsp_if.source rsp,
    aimd_cfg_if.sink   cfg
);

    logic [aimd_pkg::TIME_W-1:0] thr_reg;
    logic [aimd_pkg::BETA_W-1:0] beta_reg;
    logic [aimd_pkg::TIME_W-1:0] gap_reg;

    aimd_pkg::cfg_t       cfg_regs;
    aimd_pkg::budget_wr_t budget_wr;
    aimd_pkg::cmd_t       push_cmd;
    aimd_pkg::cmd_t       head;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_valid;
    logic                 cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= '0;
            beta_reg <= aimd_pkg::BETA_RESET;
            gap_reg  <= aimd_pkg::GAP_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                aimd_pkg::CFG_THRESHOLD: thr_reg  <= cfg.data;
                aimd_pkg::CFG_BETA:      beta_reg <= cfg.data[aimd_pkg::BETA_W-1:0];
                aimd_pkg::CFG_GAP:       gap_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg_regs.delay_threshold = thr_reg;
    assign cfg_regs.beta_q16        = beta_reg;
    assign cfg_regs.packet_gap      = gap_reg;
    assign budget_wr.load           = cfg_wr && (cfg.index == aimd_pkg::CFG_BUDGET);
    assign budget_wr.value          = cfg.data[aimd_pkg::CNT_W-1:0];

    aimd_front u_front (
        .req             (req),
        .delay_threshold (cfg_regs.delay_threshold),
        .q_full          (q_full),
        .push            (push),
        .cmd             (push_cmd)
    );

    aimd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    aimd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .cmd       (head),
        .pop       (pop),
        .cfg_regs  (cfg_regs),
        .budget_wr (budget_wr),
        .rsp       (rsp)
    );

endmodule
